[rtl/lzw_pkg.sv]
// Shared types and constants for the LZW compressor.
package lzw_pkg;
	localparam int CODE_BITS = 12;
	localparam int SYM_BITS = 8;
	localparam int FIRST_FREE_CODE = 256;
	localparam int DICT_CODES = 4096;
	localparam int CODE_LIMIT = (DICT_CODES < (1 << CODE_BITS)) ? DICT_CODES : (1 << CODE_BITS);
	localparam int NFC_BITS = CODE_BITS + 1;
	localparam int HASH_BITS = 12;
	localparam int HASH_DEPTH = 1 << HASH_BITS;
	localparam int EPOCH_BITS = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PROBE,
		ST_CHECK,
		ST_EMIT,
		ST_FLUSH
	} lzw_state_t;

	typedef struct packed {
		logic clear_start;
		logic clear_step;
		logic load_first;
		logic probe;
		logic step_probe;
		logic take_hit;
		logic learn;
		logic emit_prefix;
		logic emit_last;
		logic restart;
	} lzw_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic prefix_valid;
		logic hit;
		logic miss;
		logic out_busy;
		logic epoch_wrap;
	} lzw_status_t;

	function automatic logic [HASH_BITS-1:0] hash_pair(input logic [CODE_BITS-1:0] pre,
		input logic [SYM_BITS-1:0] sym);
		logic [23:0] v;
		v = {{(24-CODE_BITS){1'b0}}, pre} ^ {sym, 16'h0} ^ {8'h0, sym, 8'h0} ^ {16'h0, sym};
		return v[HASH_BITS-1:0] ^ v[23:24-HASH_BITS] ^ {sym[3:0], sym};
	endfunction
endpackage

[rtl/lzw_compressor.sv]
// Top level of the greedy 12-bit LZW compressor.
// Input: s_axis carries one byte per transaction; tuser marks the last byte
// of a stream. Output: m_axis carries 12-bit codes; tlast marks the final
// code of a stream, after which the dictionary starts fresh.
// Each byte after the first of a stream is looked up at its hashed slot
// in the 4096-slot dictionary memory, then at the following slots by linear
// probing until a hit or an empty slot; a miss emits a code. No new byte is
// accepted until then. The single read port reads one slot per probe step.
// After reset a clearing pass writes every slot of the memory; no byte is
// accepted during it. Each stream then advances a 4-bit epoch mark, so
// entries of older streams read as empty; after every 15th stream the
// epoch wraps and the same clearing pass runs again before the next byte.
// The output register holds a code until taken; a stalled receiver stops
// the controller before it emits the next code, never losing one.
module lzw_compressor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] symbol
	input  logic        s_axis_tuser,  // [0] end_of_stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [11:0] code, [15:12] zero
	output logic        m_axis_tlast
);
	import lzw_pkg::*;

	lzw_cmd_t cmd;
	lzw_status_t status;
	logic eos_flag;
	logic [CODE_BITS-1:0] code;

	lzw_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.eos_flag(eos_flag), .status(status), .cmd(cmd)
	);

	lzw_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.in_symbol(s_axis_tdata), .in_eos(s_axis_tuser), .eos_flag(eos_flag),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_code(code), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {(16-CODE_BITS)'(0), code};
endmodule

[rtl/lzw_datapath.sv]
// Datapath: hashed dictionary memory with epoch marks, prefix and output registers.
module lzw_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lzw_pkg::lzw_cmd_t             cmd,
	output lzw_pkg::lzw_status_t          status,
	input  logic [7:0]                    in_symbol,
	input  logic                          in_eos,
	output logic                          eos_flag,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lzw_pkg::CODE_BITS-1:0] out_code,
	output logic                          out_last
);
	import lzw_pkg::*;

	// entry: epoch, prefix, symbol, code; epoch 0 marks a cleared slot
	localparam int ENTRY_W = EPOCH_BITS + CODE_BITS + SYM_BITS + CODE_BITS;
	logic [ENTRY_W-1:0] mem [HASH_DEPTH];
	logic [ENTRY_W-1:0] rd_q;
	logic [HASH_BITS-1:0] addr_q;
	logic [HASH_BITS-1:0] clr_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic clear_done_q;
	logic [CODE_BITS-1:0] prefix_q;
	logic prefix_valid_q;
	logic [SYM_BITS-1:0] sym_q;
	logic eos_q;
	logic [NFC_BITS-1:0] nfc_q;
	logic [CODE_BITS-1:0] wr_code;
	logic [EPOCH_BITS-1:0] rd_epoch;
	logic [CODE_BITS-1:0] rd_pre;
	logic [SYM_BITS-1:0] rd_sym;
	logic [CODE_BITS-1:0] rd_code;
	logic slot_used;
	logic room;

	assign {rd_epoch, rd_pre, rd_sym, rd_code} = rd_q;
	assign slot_used = (rd_epoch == epoch_q);
	assign room = (nfc_q < NFC_BITS'(CODE_LIMIT));
	assign wr_code = nfc_q[CODE_BITS-1:0];
	assign status.clear_done = clear_done_q;
	assign status.prefix_valid = prefix_valid_q;
	assign status.hit = slot_used && rd_pre == prefix_q && rd_sym == sym_q;
	assign status.miss = !slot_used;
	assign status.out_busy = out_valid && !out_ready;
	assign status.epoch_wrap = &epoch_q;
	assign eos_flag = eos_q;

	always_ff @(posedge clk) begin
		if (cmd.clear_step)
			mem[clr_q] <= '0;
		else if (cmd.learn && room)
			mem[addr_q] <= {epoch_q, prefix_q, sym_q, wr_code};
		rd_q <= mem[cmd.probe ? hash_pair(prefix_q, in_symbol) :
			cmd.step_probe ? addr_q + 1'b1 : addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clear_done_q <= 1'b0;
			epoch_q <= EPOCH_BITS'(1);
			addr_q <= '0;
			prefix_q <= '0;
			prefix_valid_q <= 1'b0;
			sym_q <= '0;
			eos_q <= 1'b0;
			nfc_q <= NFC_BITS'(FIRST_FREE_CODE);
			out_valid <= 1'b0;
			out_code <= '0;
			out_last <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + 1'b1;
				if (&clr_q) clear_done_q <= 1'b1;
			end
			if (cmd.load_first) begin
				prefix_q <= CODE_BITS'(in_symbol);
				prefix_valid_q <= 1'b1;
				eos_q <= in_eos;
			end
			if (cmd.probe) begin
				addr_q <= hash_pair(prefix_q, in_symbol);
				sym_q <= in_symbol;
				eos_q <= in_eos;
			end
			if (cmd.step_probe) addr_q <= addr_q + 1'b1;
			if (cmd.take_hit) prefix_q <= rd_code;
			if (cmd.learn && room) nfc_q <= nfc_q + 1'b1;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cmd.emit_prefix) begin
				out_valid <= 1'b1;
				out_code <= prefix_q;
				out_last <= cmd.emit_last;
				if (!cmd.emit_last) prefix_q <= CODE_BITS'(sym_q);
			end
			if (cmd.restart) begin
				prefix_valid_q <= 1'b0;
				nfc_q <= NFC_BITS'(FIRST_FREE_CODE);
				epoch_q <= epoch_q + 1'b1;
				eos_q <= 1'b0;
			end
			if (cmd.clear_start) begin
				clr_q <= '0;
				clear_done_q <= 1'b0;
				epoch_q <= EPOCH_BITS'(1);
			end
		end
	end
endmodule

[rtl/lzw_controller.sv]
// Controller state machine sequencing clear, probe, learn and emit.
module lzw_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 eos_flag,
	input  lzw_pkg::lzw_status_t status,
	output lzw_pkg::lzw_cmd_t    cmd
);
	import lzw_pkg::*;

	lzw_state_t state_q, state_d;
	logic accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (status.clear_done) state_d = ST_IDLE;
			ST_IDLE: if (accept) state_d = status.prefix_valid ? ST_CHECK : ST_PROBE;
			ST_PROBE: if (eos_flag) state_d = ST_FLUSH; else state_d = ST_IDLE;
			ST_CHECK: begin
				if (status.hit) state_d = eos_flag ? ST_FLUSH : ST_IDLE;
				else if (status.miss) state_d = ST_EMIT;
			end
			ST_EMIT: if (!status.out_busy) state_d = eos_flag ? ST_FLUSH : ST_IDLE;
			ST_FLUSH: if (!status.out_busy) state_d = status.epoch_wrap ? ST_CLEAR : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clear_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					cmd.load_first = !status.prefix_valid;
					cmd.probe = status.prefix_valid;
				end
			end
			ST_PROBE: ;
			ST_CHECK: begin
				if (status.hit) cmd.take_hit = 1'b1;
				else if (!status.miss) cmd.step_probe = 1'b1;
			end
			ST_EMIT: if (!status.out_busy) begin
				cmd.emit_prefix = 1'b1;
				cmd.learn = 1'b1;
			end
			ST_FLUSH: if (!status.out_busy) begin
				cmd.emit_prefix = 1'b1;
				cmd.emit_last = 1'b1;
				cmd.restart = 1'b1;
				cmd.clear_start = status.epoch_wrap;
			end
			default: ;
		endcase
	end
endmodule

[test/lzw_compressor_test.sv]
// Testbench for the LZW compressor: byte streams in, codes checked against a predictor.
`timescale 1ns / 1ps
module lzw_compressor_test;
	import lzw_pkg::*;

	typedef struct {
		bit [7:0] sym;
		bit eos;
		bit typed;
		bit [11:0] typed_code;
	} byte_row_t;

	typedef struct {
		bit [11:0] code;
		bit last;
	} code_item_t;

	localparam int IDLE_LIMIT = 50000;
	localparam int HOLD_CYCLES = 400;
	localparam int CALM_ITEMS = 300;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 0;
	logic s_axis_tuser = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	logic m_axis_tlast;

	lzw_compressor uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	byte_row_t stim[$];
	code_item_t pending_codes[$];
	bit [11:0] dict_code[bit [19:0]];
	bit [12:0] next_code = FIRST_FREE_CODE;
	bit [11:0] cur_prefix = 0;
	bit have_prefix = 0;
	int errors = 0;
	int codes_seen = 0;
	bit calm = 0;
	bit sending_done = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task automatic push_code(input bit [11:0] code, input bit last, input bit keep);
		code_item_t c;
		c.code = code;
		c.last = last;
		if (keep)
			pending_codes.push_back(c);
	endtask

	// advance the dictionary by one byte; keep=0 only updates state
	task automatic compress_byte(input bit [7:0] sym, input bit eos, input bit keep);
		bit [19:0] key;
		key = {cur_prefix, sym};
		if (!have_prefix) begin
			cur_prefix = sym;
			have_prefix = 1;
		end else if (dict_code.exists(key)) begin
			cur_prefix = dict_code[key];
		end else begin
			push_code(cur_prefix, 0, keep);
			if (next_code < CODE_LIMIT) begin
				dict_code[key] = next_code[11:0];
				next_code++;
			end
			cur_prefix = sym;
		end
		if (eos) begin
			push_code(cur_prefix, 1, keep);
			dict_code.delete();
			next_code = FIRST_FREE_CODE;
			cur_prefix = 0;
			have_prefix = 0;
		end
	endtask

	task automatic add_row(input bit [7:0] sym, input bit eos, input bit typed,
		input bit [11:0] code);
		byte_row_t r;
		r.sym = sym;
		r.eos = eos;
		r.typed = typed;
		r.typed_code = code;
		stim.push_back(r);
	endtask

	task automatic add_stream(input int len, input bit narrow);
		bit [7:0] base;
		bit [7:0] span;
		base = $urandom;
		span = $urandom_range(1, 4);
		for (int i = 0; i < len; i++)
			add_row(narrow ? base + 8'($urandom % span) : 8'($urandom), i == len - 1, 0, 0);
	endtask

	task automatic build_stimulus();
		int n;
		// single-byte streams: code equals the byte
		add_row(8'h00, 1, 1, 12'h000);
		add_row(8'hFF, 1, 1, 12'h0FF);
		add_row(8'h0A, 1, 1, 12'h00A);
		add_row(8'h80, 1, 1, 12'h080);
		for (int i = 0; i < 7; i++)
			add_row(i % 2 ? 8'd66 : 8'd65, i == 6, 0, 0);
		for (int i = 0; i < 7; i++)
			add_row(8'h00, i == 6, 0, 0);
		add_row(8'd10, 0, 0, 0);
		add_row(8'd32, 0, 0, 0);
		add_row(8'hFF, 0, 0, 0);
		add_row(8'h00, 0, 0, 0);
		add_row(8'hFF, 0, 0, 0);
		add_row(8'h00, 1, 0, 0);
		// long random stream grows a large dictionary
		add_stream(900, 0);
		n = 0;
		while (n < 680) begin
			int len;
			len = ($urandom % 8 == 0) ? $urandom_range(1, 3) : $urandom_range(4, 80);
			add_stream(len, $urandom % 4 != 0);
			n += len;
		end
	endtask

	initial begin
		build_stimulus();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		for (int i = 0; i < stim.size(); i++) begin
			if (i >= stim.size() - CALM_ITEMS)
				calm = 1;
			if (!calm && i > 0 && $urandom % 4 == 0) begin
				s_axis_tvalid <= 0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			s_axis_tvalid <= 1;
			s_axis_tdata <= stim[i].sym;
			s_axis_tuser <= stim[i].eos;
			@(posedge clk);
			while (!s_axis_tready)
				@(posedge clk);
			if (stim[i].typed) begin
				push_code(stim[i].typed_code, 1, 1);
				compress_byte(stim[i].sym, stim[i].eos, 0);
			end else begin
				compress_byte(stim[i].sym, stim[i].eos, 1);
			end
		end
		s_axis_tvalid <= 0;
		sending_done = 1;
		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_codes.size() == 0)
			$display("[lzw_compressor] OK");
		else
			$display("[lzw_compressor] ERROR");
		$finish;
	end

	initial begin
		bit held;
		bit v;
		int len;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (calm) begin
				v = 1;
				len = 1;
			end else if (!held && codes_seen > 200) begin
				v = 0;
				len = HOLD_CYCLES;
				held = 1;
			end else begin
				v = $urandom % 3 != 0;
				len = $urandom_range(1, 19);
			end
			m_axis_tready <= v;
			repeat (len) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		code_item_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			codes_seen++;
			if (pending_codes.size() == 0) begin
				report_mismatch($sformatf("unexpected code %0d", m_axis_tdata));
			end else begin
				e = pending_codes.pop_front();
				if (m_axis_tdata !== {4'b0, e.code})
					report_mismatch($sformatf("code %0d, want %0d", m_axis_tdata, e.code));
				if (m_axis_tlast !== e.last)
					report_mismatch($sformatf("tlast %0b, want %0b", m_axis_tlast, e.last));
			end
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout waiting for a transaction");
			$display("[lzw_compressor] ERROR");
			$finish;
		end
	end
endmodule

[files.f]
rtl/lzw_pkg.sv
rtl/lzw_datapath.sv
rtl/lzw_controller.sv
rtl/lzw_compressor.sv
test/lzw_compressor_test.sv
